FILE: hdl/triangle_face_normal_unit_macros.svh
// assertion macros for the triangle face normal unit
// no dependencies; the including module must provide clk and rst
`ifndef TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TFN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("triangle face normal: same-cycle check failed");

// next-cycle implication, disabled during reset
`define TFN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("triangle face normal: next-cycle check failed");

`endif

FILE: hdl/tfn_pkg.sv
// shared widths and types for the triangle face normal unit
// no dependencies
`default_nettype none

package tfn_pkg;

  localparam int COORD_WIDTH      = 16;
  localparam int NORMAL_FRAC_BITS = 14;

  localparam int EDGE_W  = COORD_WIDTH + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int BLEN_W  = $clog2(CROSS_W + 1);
  localparam int NORM_BITS = 30;
  localparam int SQ_W    = 2 * NORM_BITS;
  localparam int SUM_W   = SQ_W + 2;
  localparam int ROOT_W  = SUM_W / 2;
  localparam int REM_W   = ROOT_W + 3;
  localparam int Q_W     = NORMAL_FRAC_BITS + 1;
  localparam int NUM_W   = NORM_BITS + NORMAL_FRAC_BITS + 1;
  localparam int DREM_W  = ROOT_W + 1;
  localparam int OUT_W   = NORMAL_FRAC_BITS + 2;

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [EDGE_W-1:0]      edge_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [CROSS_W-1:0]     cross_t;
  typedef logic signed [OUT_W-1:0]       norm_t;

  // per-item side data that travels beside the sqrt and divide pipes
  typedef struct packed {
    logic [2:0][NORM_BITS-1:0] r;
    logic [2:0]                neg;
    logic                      degen;
  } side_t;

endpackage

`default_nettype wire

FILE: hdl/triangle_face_normal_unit.sv
// Flat face normal of one triangle per beat; each result appears with done.
// Throughput one triangle per cycle: busy is high only during reset, the pipe never stalls.
// Depth: 7-stage front end, 32-stage square root, 16-stage divider, one output register.
// Synchronous active-high reset clears all valid bits; items in flight are dropped.
// The receiver cannot stall: each result is shown for one cycle with done.
`default_nettype none

module triangle_face_normal_unit import tfn_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  coord_t a_x,
  input  coord_t a_y,
  input  coord_t a_z,
  input  coord_t b_x,
  input  coord_t b_y,
  input  coord_t b_z,
  input  coord_t c_x,
  input  coord_t c_y,
  input  coord_t c_z,
  output logic   done,
  output norm_t  normal_x,
  output norm_t  normal_y,
  output norm_t  normal_z,
  output logic   degenerate
);

`include "triangle_face_normal_unit_macros.svh"

  logic                front_valid, sqrt_valid, div_valid;
  side_t               front_side, sqrt_side, div_side;
  logic [SUM_W-1:0]    front_sum;
  logic [ROOT_W-1:0]   sqrt_root;
  logic [2:0][Q_W-1:0] div_quo;
  norm_t               n_next [0:2];
  norm_t               unit_one;
  logic                norm_zero, norm_in_range;

  assign busy = rst;

  tfn_front u_front (
    .clk(clk), .rst(rst), .in_valid(start && !busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .out_valid(front_valid), .out_side(front_side), .out_sum(front_sum)
  );

  tfn_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(front_valid), .in_side(front_side),
    .in_sum(front_sum), .out_valid(sqrt_valid), .out_side(sqrt_side),
    .out_root(sqrt_root)
  );

  tfn_div u_div (
    .clk(clk), .rst(rst), .in_valid(sqrt_valid), .in_side(sqrt_side),
    .in_len(sqrt_root), .out_valid(div_valid), .out_side(div_side),
    .out_quo(div_quo)
  );

  // saturate at one, restore sign, zero for a degenerate triangle
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      logic [Q_W-1:0] m;
      m = (div_quo[i] > Q_W'(1 << NORMAL_FRAC_BITS)) ? Q_W'(1 << NORMAL_FRAC_BITS)
                                                      : div_quo[i];
      if (div_side.degen) begin
        n_next[i] = '0;
      end else if (div_side.neg[i]) begin
        n_next[i] = -norm_t'(m);
      end else begin
        n_next[i] = norm_t'(m);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    normal_x   <= n_next[0];
    normal_y   <= n_next[1];
    normal_z   <= n_next[2];
    degenerate <= div_side.degen;
  end

  // result checks
  assign unit_one      = norm_t'(1 << NORMAL_FRAC_BITS);
  assign norm_zero     = (normal_x == '0) && (normal_y == '0) && (normal_z == '0);
  assign norm_in_range = (normal_x <= unit_one) && (normal_x >= -unit_one) &&
                         (normal_y <= unit_one) && (normal_y >= -unit_one) &&
                         (normal_z <= unit_one) && (normal_z >= -unit_one);

  `TFN_ASSERT_NXT(a_degen_zero, div_valid && div_side.degen, done && degenerate && norm_zero)
  `TFN_ASSERT_IMP(a_live_nonzero, done && !degenerate, !norm_zero)
  `TFN_ASSERT_IMP(a_unit_bound, done, norm_in_range)

endmodule

`default_nettype wire

FILE: hdl/tfn_front.sv
// front end: edges, cross product, normalization shift, sum of squares
// depends on tfn_pkg
`default_nettype none

module tfn_front import tfn_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  coord_t           a_x,
  input  coord_t           a_y,
  input  coord_t           a_z,
  input  coord_t           b_x,
  input  coord_t           b_y,
  input  coord_t           b_z,
  input  coord_t           c_x,
  input  coord_t           c_y,
  input  coord_t           c_z,
  output logic             out_valid,
  output side_t            out_side,
  output logic [SUM_W-1:0] out_sum
);

  logic [7:1] v;
  edge_t ux, uy, uz, vx, vy, vz;
  prod_t p [0:5];
  logic [2:0][CROSS_W-1:0] mag3, mag4;
  logic [2:0] neg3, neg4;
  logic [BLEN_W-1:0] blen, blen_next;
  logic degen4;
  side_t side5, side6, side7;
  logic [SQ_W-1:0] sq [0:2];
  logic [2:0][NORM_BITS-1:0] r_next;
  cross_t c_next [0:2];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[6:1], in_valid};
    end
  end

  // stage 1: edge vectors
  always_ff @(posedge clk) begin
    ux <= edge_t'(b_x) - edge_t'(a_x);
    uy <= edge_t'(b_y) - edge_t'(a_y);
    uz <= edge_t'(b_z) - edge_t'(a_z);
    vx <= edge_t'(c_x) - edge_t'(a_x);
    vy <= edge_t'(c_y) - edge_t'(a_y);
    vz <= edge_t'(c_z) - edge_t'(a_z);
  end

  // stage 2: six products
  always_ff @(posedge clk) begin
    p[0] <= uy * vz;
    p[1] <= uz * vy;
    p[2] <= uz * vx;
    p[3] <= ux * vz;
    p[4] <= ux * vy;
    p[5] <= uy * vx;
  end

  // stage 3: cross components as sign and magnitude
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      c_next[i] = cross_t'(p[2*i]) - cross_t'(p[2*i+1]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      neg3[i] <= c_next[i][CROSS_W-1];
      mag3[i] <= c_next[i][CROSS_W-1] ? CROSS_W'(-c_next[i]) : CROSS_W'(c_next[i]);
    end
  end

  // stage 4: bit length of the largest magnitude
  always_comb begin
    logic [CROSS_W-1:0] any;
    any = mag3[0] | mag3[1] | mag3[2];
    blen_next = '0;
    for (int b = 0; b < CROSS_W; b++) begin
      if (any[b]) begin
        blen_next = BLEN_W'(b + 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mag4   <= mag3;
    neg4   <= neg3;
    blen   <= blen_next;
    degen4 <= (blen_next == '0);
  end

  // stage 5: scale so the largest magnitude is exactly NORM_BITS long
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (blen > BLEN_W'(NORM_BITS)) begin
        r_next[i] = NORM_BITS'(mag4[i] >> (blen - BLEN_W'(NORM_BITS)));
      end else begin
        r_next[i] = NORM_BITS'(mag4[i] << (BLEN_W'(NORM_BITS) - blen));
      end
    end
  end

  always_ff @(posedge clk) begin
    side5.r     <= r_next;
    side5.neg   <= neg4;
    side5.degen <= degen4;
  end

  // stage 6: squares
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sq[i] <= side5.r[i] * side5.r[i];
    end
    side6 <= side5;
  end

  // stage 7: sum of squares
  always_ff @(posedge clk) begin
    out_sum <= SUM_W'(sq[0]) + SUM_W'(sq[1]) + SUM_W'(sq[2]);
    side7   <= side6;
  end

  assign out_valid = v[7];
  assign out_side  = side7;

endmodule

`default_nettype wire

FILE: hdl/tfn_sqrt.sv
// pipelined integer square root, one root bit per stage
// depends on tfn_pkg
`default_nettype none

module tfn_sqrt import tfn_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  side_t             in_side,
  input  logic [SUM_W-1:0]  in_sum,
  output logic              out_valid,
  output side_t             out_side,
  output logic [ROOT_W-1:0] out_root
);

  logic [ROOT_W:0]   v;
  side_t             side [0:ROOT_W];
  logic [SUM_W-1:0]  rad  [0:ROOT_W];
  logic [REM_W-1:0]  rem  [0:ROOT_W];
  logic [ROOT_W-1:0] q    [0:ROOT_W];

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[ROOT_W-1:0], in_valid};
    end
  end

  // input stage
  always_ff @(posedge clk) begin
    side[0] <= in_side;
    rad[0]  <= in_sum;
    rem[0]  <= '0;
    q[0]    <= '0;
  end

  // one root bit per stage, two radicand bits consumed
  for (genvar k = 1; k <= ROOT_W; k++) begin : g_step
    logic [REM_W-1:0] rem_sh, trial;
    assign rem_sh = {rem[k-1][REM_W-3:0], rad[k-1][SUM_W-1-2*(k-1) -: 2]};
    assign trial  = REM_W'({q[k-1], 2'b01});

    always_ff @(posedge clk) begin
      side[k] <= side[k-1];
      rad[k]  <= rad[k-1];
      if (rem_sh >= trial) begin
        rem[k] <= rem_sh - trial;
        q[k]   <= {q[k-1][ROOT_W-2:0], 1'b1};
      end else begin
        rem[k] <= rem_sh;
        q[k]   <= {q[k-1][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[ROOT_W];
  assign out_side  = side[ROOT_W];
  assign out_root  = q[ROOT_W];

endmodule

`default_nettype wire

FILE: hdl/tfn_div.sv
// pipelined rounded division of three components by the length
// depends on tfn_pkg
`default_nettype none

module tfn_div import tfn_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  side_t               in_side,
  input  logic [ROOT_W-1:0]   in_len,
  output logic                out_valid,
  output side_t               out_side,
  output logic [2:0][Q_W-1:0] out_quo
);

  logic [Q_W:0]               v;
  side_t                      side [0:Q_W];
  logic [ROOT_W-1:0]          len  [0:Q_W];
  logic [2:0][Q_W-1:0]        lo   [0:Q_W];
  logic [2:0][DREM_W-1:0]     rem  [0:Q_W];
  logic [2:0][Q_W-1:0]        q    [0:Q_W];
  logic [2:0][NUM_W-1:0]      num;

  // valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= {v[Q_W-1:0], in_valid};
    end
  end

  // numerator with half the divisor added for rounding
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num[i] = NUM_W'({in_side.r[i], {NORMAL_FRAC_BITS{1'b0}}}) + NUM_W'(in_len >> 1);
    end
  end

  // input stage: high part of the numerator is already below the divisor
  always_ff @(posedge clk) begin
    side[0] <= in_side;
    len[0]  <= in_len;
    for (int i = 0; i < 3; i++) begin
      rem[0][i] <= DREM_W'(num[i] >> Q_W);
      lo[0][i]  <= num[i][Q_W-1:0];
      q[0][i]   <= '0;
    end
  end

  // one quotient bit per stage, three lanes
  for (genvar k = 1; k <= Q_W; k++) begin : g_step
    logic [2:0][DREM_W-1:0] sh;
    always_comb begin
      for (int i = 0; i < 3; i++) begin
        sh[i] = {rem[k-1][i][DREM_W-2:0], lo[k-1][i][Q_W-k]};
      end
    end

    always_ff @(posedge clk) begin
      side[k] <= side[k-1];
      len[k]  <= len[k-1];
      lo[k]   <= lo[k-1];
      for (int i = 0; i < 3; i++) begin
        if (sh[i] >= DREM_W'(len[k-1])) begin
          rem[k][i] <= sh[i] - DREM_W'(len[k-1]);
          q[k][i]   <= {q[k-1][i][Q_W-2:0], 1'b1};
        end else begin
          rem[k][i] <= sh[i];
          q[k][i]   <= {q[k-1][i][Q_W-2:0], 1'b0};
        end
      end
    end
  end

  assign out_valid = v[Q_W];
  assign out_side  = side[Q_W];
  assign out_quo   = q[Q_W];

endmodule

`default_nettype wire

FILE: dv/testbench.sv
// self-checking testbench for the triangle face normal unit
// depends on tfn_pkg and triangle_face_normal_unit
`timescale 1ns / 1ps
`default_nettype none

module testbench;
  import tfn_pkg::*;

  localparam int LATENCY   = 56;
  localparam int CYCLE_CAP = 200000;

  typedef struct {
    coord_t ax, ay, az, bx, by, bz, cx, cy, cz;
  } tri_t;

  typedef struct {
    norm_t nx, ny, nz;
    logic  degen;
  } normal_t;

  logic   clk = 1'b0;
  logic   rst = 1'b1;
  logic   start = 1'b0;
  logic   busy, done, degenerate;
  coord_t a_x = '0, a_y = '0, a_z = '0, b_x = '0, b_y = '0, b_z = '0;
  coord_t c_x = '0, c_y = '0, c_z = '0;
  norm_t  normal_x, normal_y, normal_z;

  tri_t    pending_tris[$];
  normal_t expected_normals[$];
  int      errors = 0;
  int      cycles = 0;
  bit      sender_hold = 1'b0;
  bit      quiet_stretch = 1'b0;
  bit      stim_done = 1'b0;

  triangle_face_normal_unit u_top (.*);

  always #4 clk = ~clk;

  // signed 128-bit product difference, magnitude bit length, unit-length scaling
  function automatic normal_t face_normal(tri_t t);
    normal_t res;
    logic signed [127:0] ux, uy, uz, vx, vy, vz;
    logic signed [127:0] cr[3];
    logic [127:0] mag[3];
    logic [63:0]  r[3];
    logic [63:0]  s, len, n, rem, bitv;
    logic [63:0]  one;
    int blen, sh;
    one = 64'd1 << NORMAL_FRAC_BITS;
    ux = 128'(t.bx) - 128'(t.ax); uy = 128'(t.by) - 128'(t.ay);
    uz = 128'(t.bz) - 128'(t.az);
    vx = 128'(t.cx) - 128'(t.ax); vy = 128'(t.cy) - 128'(t.ay);
    vz = 128'(t.cz) - 128'(t.az);
    cr[0] = uy * vz - uz * vy;
    cr[1] = uz * vx - ux * vz;
    cr[2] = ux * vy - uy * vx;
    blen = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = cr[i] < 0 ? -cr[i] : cr[i];
      for (int b = 0; b < 128; b++) if (mag[i][b] && b + 1 > blen) blen = b + 1;
    end
    res.nx = '0; res.ny = '0; res.nz = '0; res.degen = 1'b1;
    if (blen == 0) return res;
    sh = blen - 30;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      r[i] = sh >= 0 ? 64'(mag[i] >> sh) : 64'(mag[i] << (-sh));
      s += r[i] * r[i];
    end
    // bitwise integer square root
    rem = s; len = 0; bitv = 64'd1 << 62;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= len + bitv) begin
        rem -= len + bitv;
        len = (len >> 1) + bitv;
      end else begin
        len >>= 1;
      end
      bitv >>= 2;
    end
    for (int i = 0; i < 3; i++) begin
      n = ((r[i] << NORMAL_FRAC_BITS) + (len >> 1)) / len;
      if (n > one) n = one;
      if (cr[i] < 0) n = -n;
      case (i)
        0: res.nx = norm_t'(n);
        1: res.ny = norm_t'(n);
        default: res.nz = norm_t'(n);
      endcase
    end
    res.degen = 1'b0;
    return res;
  endfunction

  function automatic coord_t rand_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(0, 15) - 8);
      2: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(0, 2047) - 1024);
    endcase
  endfunction

  // directed then random triangles
  initial begin
    tri_t t;
    int mode;
    t = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000,
          16'sh8000, 16'sh7fff, 16'sh8000};
    pending_tris.push_back(t);
    t = '{16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh7fff,
          16'sh7fff, 16'sh8000, 16'sh7fff};
    pending_tris.push_back(t);
    // degenerate: all equal, collinear, zeros
    pending_tris.push_back('{default: 16'sh0});
    pending_tris.push_back('{default: 16'sh1234});
    pending_tris.push_back('{0, 0, 0, 1, 1, 1, 2, 2, 2});
    pending_tris.push_back('{16'sh8000, 16'sh8000, 16'sh8000, 0, 0, 0,
                             16'sh7fff, 16'sh7fff, 16'sh7fff});
    // axis-aligned and tiny
    pending_tris.push_back('{0, 0, 0, 1, 0, 0, 0, 1, 0});
    pending_tris.push_back('{0, 0, 0, 0, 1, 0, 1, 0, 0});
    pending_tris.push_back('{0, 0, 0, 0, 0, 1, 0, 1, 0});
    pending_tris.push_back('{0, 0, 0, 1, 0, 0, 0, 0, -1});
    // huge extremes on every axis, largest cross products, then two small triangles
    pending_tris.push_back('{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                             16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
    pending_tris.push_back('{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff,
                             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
    pending_tris.push_back('{1, 1, 0, 2, 1, 0, 1, 3, 5});
    pending_tris.push_back('{16'shffff, 16'shffff, 16'shffff, 0, 16'shffff, 16'shffff,
                             16'shffff, 0, 16'shffff});
    for (int k = 0; k < 950; k++) begin
      mode = $urandom_range(0, 3);
      t.ax = rand_coord(mode); t.ay = rand_coord(mode); t.az = rand_coord(mode);
      t.bx = rand_coord(mode); t.by = rand_coord(mode); t.bz = rand_coord(mode);
      t.cx = rand_coord(mode); t.cy = rand_coord(mode); t.cz = rand_coord(mode);
      // occasional collinear triangle for the flag
      if ($urandom_range(0, 19) == 0) begin
        t.cx = t.bx; t.cy = t.by; t.cz = t.bz;
      end
      pending_tris.push_back(t);
    end
  end

  // driver: one beat per accepted edge, random gaps
  always @(posedge clk) begin
    tri_t t;
    cycles <= cycles + 1;
    if (cycles == 3) rst <= 1'b0;
    quiet_stretch <= (cycles > 600 && cycles < 900);
    if (cycles == 300) sender_hold <= 1'b1;
    if (sender_hold && expected_normals.size() == 0 && !(start && !busy)) sender_hold <= 1'b0;
    if (start && !busy) expected_normals.push_back(face_normal(
        '{a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z}));
    if (!rst && !(start && busy)) begin
      if (pending_tris.size() != 0 && !sender_hold &&
          (quiet_stretch || $urandom_range(0, 99) >= 19)) begin
        t = pending_tris.pop_front();
        start <= 1'b1;
        a_x <= t.ax; a_y <= t.ay; a_z <= t.az;
        b_x <= t.bx; b_y <= t.by; b_z <= t.bz;
        c_x <= t.cx; c_y <= t.cy; c_z <= t.cz;
      end else begin
        start <= 1'b0;
        if (pending_tris.size() == 0) stim_done <= 1'b1;
      end
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    normal_t e;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: unexpected beat %0d %0d %0d %0b", $time, normal_x, normal_y,
                 normal_z, degenerate);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (normal_x !== e.nx || normal_y !== e.ny || normal_z !== e.nz ||
            degenerate !== e.degen) begin
          $display("%0t: expected %0d %0d %0d %0b, got %0d %0d %0d %0b", $time,
                   e.nx, e.ny, e.nz, e.degen, normal_x, normal_y, normal_z, degenerate);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    fork
      begin
        wait (stim_done && !start);
        wait (expected_normals.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
      end
      wait (cycles >= CYCLE_CAP);
    join_any
    if (cycles >= CYCLE_CAP || !stim_done || expected_normals.size() != 0) begin
      $display("Mismatches found");
    end else if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire
